FILE: rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad combination lock
// Key classification record, queue status, register indexes and the
// key value and seven-segment lookup tables.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD_TICKS = 8'd1;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
   localparam logic [7:0] SCAN_PERIOD_RESET = 8'd2;
   localparam logic [7:0] TIMER_MAX = 8'hFF;
   localparam logic [7:0] SEG_BLANK = 8'hFF;
   localparam logic [4:0] NO_KEY = 5'd16;
   localparam logic [1:0] LAST_COLUMN = 2'd3;

   typedef struct packed {
      logic       pressed;
      logic [1:0] row;
   } key_class_type;

   typedef struct packed {
      logic          valid;
      key_class_type item;
   } queue_head_type;

   // digit value of key position row*4+column
   function automatic logic [3:0] key_value(input logic [3:0] pos);
      logic [3:0] v;
      case (pos)
         4'd0:  v = 4'd1;
         4'd1:  v = 4'd2;
         4'd2:  v = 4'd3;
         4'd3:  v = 4'd10;
         4'd4:  v = 4'd4;
         4'd5:  v = 4'd5;
         4'd6:  v = 4'd6;
         4'd7:  v = 4'd11;
         4'd8:  v = 4'd7;
         4'd9:  v = 4'd8;
         4'd10: v = 4'd9;
         4'd11: v = 4'd12;
         4'd12: v = 4'd14;
         4'd13: v = 4'd0;
         4'd14: v = 4'd15;
         4'd15: v = 4'd13;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   // active-low hex pattern
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] s;
      case (digit)
         4'h0: s = 8'h40;
         4'h1: s = 8'h79;
         4'h2: s = 8'h24;
         4'h3: s = 8'h30;
         4'h4: s = 8'h19;
         4'h5: s = 8'h12;
         4'h6: s = 8'h02;
         4'h7: s = 8'h78;
         4'h8: s = 8'h80;
         4'h9: s = 8'h18;
         4'hA: s = 8'h08;
         4'hB: s = 8'h03;
         4'hC: s = 8'h46;
         4'hD: s = 8'h21;
         4'hE: s = 8'h06;
         4'hF: s = 8'h0E;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/kcl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_if: channel interfaces of the keypad combination lock
// Tick request, tick response and register write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface kcl_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] row_lines;

   modport source (output valid, output row_lines, input ready);
   modport sink (input valid, input row_lines, output ready);
endinterface

interface kcl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] column_drive;
   logic [7:0] segments;
   logic [2:0] digit_select;
   logic       unlocked;
   logic       key_accepted;
   logic [3:0] key_code;

   modport source (output valid, output column_drive, output segments,
                   output digit_select, output unlocked, output key_accepted,
                   output key_code, input ready);
   modport sink (input valid, input column_drive, input segments,
                 input digit_select, input unlocked, input key_accepted,
                 input key_code, output ready);
endinterface

interface kcl_csr_if;
   import kcl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output idx, output data, input ready);
   modport sink (input valid, input idx, input data, output ready);
endinterface

FILE: rtl/core/keypad_combination_lock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_combination_lock: 4x4 keypad combination lock with display scan
// Each request transfer is one millisecond tick carrying the active-low row
// lines of the column that this tick's response reports as driven; each tick
// yields exactly one response transfer with column, display, lock and key status.
// The first group of digits taken after reset sets the code and locks;
// later groups unlock on a match and lock on a mismatch.
// A tick passes the intake queue and then the response register before its
// response can transfer. Throughput: one tick per cycle while the response
// register is empty or being taken.
// A stalled response holds its register; the two-entry queue keeps taking
// ticks until full, then request ready drops.
// Registers (csr channel, always ready): index 0 debounce_ticks, index 1
// scan_period_ticks; writes to other indexes are ignored.
// Reset clears timers, key history, the queue and the lock to unlocked with
// no code set, blanks the display and restores the register defaults.
// ----------------------------------------------------------------------------
module keypad_combination_lock #(
   parameter int CODE_DIGITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   kcl_req_if.sink    req_chan,
   kcl_rsp_if.source  rsp_chan,
   kcl_csr_if.sink    csr_chan
);
   import kcl_pkg::*;

   logic [7:0]     debounce_ff;
   logic [7:0]     scan_period_ff;
   queue_head_type head;
   logic           pop;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         scan_period_ff <= SCAN_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.idx)
            CSR_DEBOUNCE_TICKS:    debounce_ff <= csr_chan.data;
            CSR_SCAN_PERIOD_TICKS: scan_period_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   kcl_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   kcl_engine #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .debounce_ticks    (debounce_ff),
      .scan_period_ticks (scan_period_ff),
      .rsp               (rsp_chan)
   );

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("engine took a tick from an empty queue");

   a_no_code_without_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.key_accepted) |-> (rsp_chan.key_code == 4'd0))
      else $error("key code without accepted key");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0(rsp_chan.digit_select))
      else $error("more than one display digit selected");

   a_dark_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.digit_select == 3'd0) |->
         (rsp_chan.segments == SEG_BLANK))
      else $error("segments lit with no digit selected");

   a_reset_defaults: assert property (@(posedge clock)
      reset |=> (debounce_ff == DEBOUNCE_RESET && scan_period_ff == SCAN_PERIOD_RESET))
      else $error("register defaults not restored by reset");
`endif

endmodule

FILE: rtl/core/kcl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_front: tick intake and row classification
// Finds the highest pressed row of each tick and holds the result in a
// two-entry queue until the engine takes it.
// ----------------------------------------------------------------------------
module kcl_front (
   input  logic                    clock,
   input  logic                    reset,
   kcl_req_if.sink                 req,
   input  logic                    pop,
   output kcl_pkg::queue_head_type head
);
   import kcl_pkg::*;

   key_class_type slot_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          push;
   key_class_type cls;

   always_comb begin
      cls.pressed = (req.row_lines != 4'hF);
      // highest pressed row wins
      if (!req.row_lines[3]) begin
         cls.row = 2'd3;
      end else if (!req.row_lines[2]) begin
         cls.row = 2'd2;
      end else if (!req.row_lines[1]) begin
         cls.row = 2'd1;
      end else begin
         cls.row = 2'd0;
      end
   end

   assign req.ready = (count_ff != 2'd2);
   assign push = req.valid && req.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/kcl_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_engine: debounce, code entry and display scan
// Takes one classified tick per cycle unless stalled, updates timers, key
// history, attempt and code digits and display, and registers the response.
// ----------------------------------------------------------------------------
module kcl_engine #(
   parameter int CODE_DIGITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kcl_pkg::queue_head_type head,
   output logic                   pop,
   input  logic [7:0]             debounce_ticks,
   input  logic [7:0]             scan_period_ticks,
   kcl_rsp_if.source              rsp
);
   import kcl_pkg::*;

   localparam int EW = $clog2(CODE_DIGITS + 1);
   localparam int IW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int CMPW = (EW > 2) ? EW : 2;
   localparam logic [EW-1:0] FULL_COUNT = EW'(CODE_DIGITS);

   logic [1:0]    scan_col_ff, scan_col_in;
   logic [7:0]    col_timer_ff, col_timer_in;
   logic [7:0]    change_timer_ff, change_timer_in;
   logic [4:0]    last_key_ff [4];
   logic [EW-1:0] entry_count_ff, entry_count_in;
   logic          locked_ff, locked_in;
   logic          code_set_ff, code_set_in;
   logic [7:0]    disp_seg_ff, disp_seg_in;
   logic [2:0]    disp_sel_ff, disp_sel_in;
   logic [3:0]    attempt_ff [CODE_DIGITS];
   logic [3:0]    attempt_in [CODE_DIGITS];
   logic [3:0]    code_ff [CODE_DIGITS];
   logic          rsp_valid_ff;
   logic [1:0]    col_out_ff;
   logic          key_acc_ff;
   logic [3:0]    key_code_ff;

   logic [7:0]    col_timer_inc;
   logic [4:0]    key;
   logic          change;
   logic          accepted;
   logic [IW-1:0] wr_idx;
   logic [EW-1:0] count_after;
   logic          full;
   logic          match;
   logic          code_store;
   logic          scan_load;
   logic [IW-1:0] disp_pos;

   assign pop = head.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      change_timer_in = (change_timer_ff == TIMER_MAX) ? TIMER_MAX
                                                       : change_timer_ff + 8'd1;
      col_timer_inc = (col_timer_ff == TIMER_MAX) ? TIMER_MAX : col_timer_ff + 8'd1;

      key = head.item.pressed ? {1'b0, head.item.row, scan_col_ff} : NO_KEY;
      change = (last_key_ff[scan_col_ff] != key) && (change_timer_in > debounce_ticks);
      accepted = change && head.item.pressed;
      if (change) begin
         change_timer_in = 8'd0;
      end

      // a full group restarts at the first digit
      wr_idx = (entry_count_ff >= FULL_COUNT) ? '0 : IW'(entry_count_ff);
      count_after = entry_count_ff;
      if (accepted) begin
         count_after = (entry_count_ff >= FULL_COUNT) ? EW'(1)
                                                      : entry_count_ff + EW'(1);
      end

      match = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         attempt_in[i] = (accepted && wr_idx == IW'(i)) ? key_value(key[3:0])
                                                         : attempt_ff[i];
         if (code_ff[i] != attempt_in[i]) begin
            match = 1'b0;
         end
      end

      full = (count_after == FULL_COUNT);
      code_store = full && !code_set_ff;
      entry_count_in = count_after;
      locked_in = locked_ff;
      code_set_in = code_set_ff;
      if (code_store) begin
         entry_count_in = '0;
         locked_in = 1'b1;
         code_set_in = 1'b1;
      end else if (full && accepted) begin
         locked_in = !match;
      end

      // display follows the scan, newest digit on digit one
      scan_load = (col_timer_inc >= scan_period_ticks);
      scan_col_in = scan_col_ff;
      col_timer_in = col_timer_inc;
      disp_seg_in = disp_seg_ff;
      disp_sel_in = disp_sel_ff;
      disp_pos = IW'(entry_count_in - EW'(1) - EW'(scan_col_ff));
      if (scan_load) begin
         scan_col_in = scan_col_ff + 2'd1;
         col_timer_in = 8'd0;
         disp_seg_in = SEG_BLANK;
         if (scan_col_ff == LAST_COLUMN) begin
            disp_sel_in = 3'd0;
         end else begin
            disp_sel_in = 3'b001 << scan_col_ff;
            if (CMPW'(entry_count_in) > CMPW'(scan_col_ff) &&
                entry_count_in != FULL_COUNT) begin
               disp_seg_in = seg_pattern(attempt_in[disp_pos]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff     <= 2'd0;
         col_timer_ff    <= 8'd0;
         change_timer_ff <= 8'd0;
         entry_count_ff  <= '0;
         locked_ff       <= 1'b0;
         code_set_ff     <= 1'b0;
         disp_seg_ff     <= SEG_BLANK;
         disp_sel_ff     <= 3'd0;
         rsp_valid_ff    <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            last_key_ff[c] <= NO_KEY;
         end
      end else begin
         if (pop) begin
            scan_col_ff     <= scan_col_in;
            col_timer_ff    <= col_timer_in;
            change_timer_ff <= change_timer_in;
            entry_count_ff  <= entry_count_in;
            locked_ff       <= locked_in;
            code_set_ff     <= code_set_in;
            disp_seg_ff     <= disp_seg_in;
            disp_sel_ff     <= disp_sel_in;
            if (change) begin
               last_key_ff[scan_col_ff] <= key;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         attempt_ff  <= attempt_in;
         col_out_ff  <= scan_col_ff;
         key_acc_ff  <= accepted;
         key_code_ff <= accepted ? key[3:0] : 4'd0;
         if (code_store) begin
            code_ff <= attempt_in;
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.column_drive = col_out_ff;
   assign rsp.segments     = disp_seg_ff;
   assign rsp.digit_select = disp_sel_ff;
   assign rsp.unlocked     = !locked_ff;
   assign rsp.key_accepted = key_acc_ff;
   assign rsp.key_code     = key_code_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the keypad combination lock
// Drives keypad ticks from a modeled 4x4 pad (code entries, matching and
// wrong groups) and from raw row noise, over several debounce and scan
// settings. Each tick's response is predicted and compared field by field.
// Both channels idle at random, and the response side stalls once for long.
// ----------------------------------------------------------------------------
module tb_top;
   import kcl_pkg::*;

   localparam int NUM_DIGITS = 4;
   localparam int RUN_LIMIT_NS = 2_000_000;
   // digit value per key position, nibble k belongs to position k
   localparam logic [63:0] DIGIT_OF_KEY = 64'hDF0E_C987_B654_A321;
   // active-low hex patterns, byte d belongs to digit d
   localparam logic [127:0] HEX_SEGMENTS = 128'h0E06_2146_0308_1880_7802_1219_3024_7940;

   typedef struct packed {
      logic [1:0] column_drive;
      logic [7:0] segments;
      logic [2:0] digit_select;
      logic       unlocked;
      logic       key_accepted;
      logic [3:0] key_code;
   } lock_status_type;

   logic clock = 1'b0;
   logic reset;

   kcl_req_if req_chan();
   kcl_rsp_if rsp_chan();
   kcl_csr_if csr_chan();

   keypad_combination_lock #(.CODE_DIGITS(NUM_DIGITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #4 clock = ~clock;

   // predicted lock state
   logic [7:0]      debounce_cfg;
   logic [7:0]      period_cfg;
   logic [1:0]      scan_col;
   logic [7:0]      col_timer;
   logic [7:0]      change_timer;
   logic [4:0]      last_key [4];
   int              digit_count;
   logic [3:0]      attempt [NUM_DIGITS];
   logic [3:0]      secret [NUM_DIGITS];
   logic            is_locked;
   logic            code_ready;
   logic [7:0]      disp_seg;
   logic [2:0]      disp_sel;
   lock_status_type status_q[$];

   // stimulus side: pending ticks and a mirror of the column scan
   logic [3:0] tick_q[$];
   int         gen_col;
   int         gen_timer;
   int         gen_period;
   logic [3:0] pad [4];
   int         secret_keys [NUM_DIGITS] = '{0, 13, 6, 11};
   logic [3:0] opening_rows [24] = '{4'hE, 4'h0, 4'hD, 4'hB, 4'hF, 4'hF, 4'hF, 4'hF,
                                     4'hE, 4'h0, 4'hD, 4'hB, 4'hF, 4'hF, 4'hF, 4'hF,
                                     4'h7, 4'h5, 4'h7, 4'h3, 4'hF, 4'hF, 4'hF, 4'hF};

   int ticks_queued = 0;
   int ticks_taken = 0;
   int results_seen = 0;
   int errors = 0;
   int req_wait;
   int rsp_wait;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit long_stall = 1'b0;

   function automatic int idle_draw(input bit calm);
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic lock_tick(input logic [3:0] rows);
      logic [1:0]      col;
      logic [4:0]      key;
      lock_status_type res;
      int              pos;
      bit              same;
      col = scan_col;
      res = '0;
      if (change_timer != TIMER_MAX) change_timer++;
      if (col_timer != TIMER_MAX) col_timer++;
      // highest pressed row wins
      key = NO_KEY;
      for (int j = 0; j < 4; j++)
         if (!rows[j]) key = {1'b0, 2'(j), col};
      if (last_key[col] != key && change_timer > debounce_cfg) begin
         change_timer = '0;
         if (key != NO_KEY) begin
            res.key_accepted = 1'b1;
            res.key_code = key[3:0];
            if (digit_count >= NUM_DIGITS) digit_count = 0;
            attempt[digit_count] = DIGIT_OF_KEY[int'(key[3:0]) * 4 +: 4];
            digit_count++;
         end
         last_key[col] = key;
      end
      if (digit_count == NUM_DIGITS) begin
         if (!code_ready) begin
            secret = attempt;
            code_ready = 1'b1;
            digit_count = 0;
            is_locked = 1'b1;
         end else if (res.key_accepted) begin
            same = 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++)
               if (secret[i] != attempt[i]) same = 1'b0;
            is_locked = !same;
         end
      end
      if (col_timer >= period_cfg) begin
         disp_seg = SEG_BLANK;
         disp_sel = '0;
         if (col != LAST_COLUMN) begin
            disp_sel = 3'(1 << col);
            if (digit_count > col && digit_count < NUM_DIGITS) begin
               pos = digit_count - 1 - col;
               disp_seg = HEX_SEGMENTS[int'(attempt[pos]) * 8 +: 8];
            end
         end
         scan_col = col + 2'd1;
         col_timer = '0;
      end
      res.column_drive = col;
      res.segments = disp_seg;
      res.digit_select = disp_sel;
      res.unlocked = !is_locked;
      status_q.push_back(res);
   endtask

   task automatic queue_tick(input bit raw_en, input logic [3:0] raw);
      if (gen_timer < 255) gen_timer++;
      tick_q.push_back(raw_en ? raw : ~pad[gen_col]);
      ticks_queued++;
      if (gen_timer >= gen_period) begin
         gen_col = (gen_col + 1) % 4;
         gen_timer = 0;
      end
   endtask

   task automatic tap_key(input int pos, input int hold);
      int r;
      int c;
      r = pos / 4;
      c = pos % 4;
      pad[c] = 4'(1 << r);
      // lower rows held too; the highest one still decides the key
      if (r > 0 && $urandom_range(0, 2) == 0)
         pad[c] = pad[c] | 4'($urandom_range(0, (1 << r) - 1));
      repeat (hold) queue_tick(1'b0, 4'h0);
      pad[c] = 4'h0;
      repeat (hold) queue_tick(1'b0, 4'h0);
   endtask

   task automatic enter_group(input int hold);
      int keys [NUM_DIGITS];
      int flip;
      int mode;
      keys = secret_keys;
      mode = $urandom_range(0, 3);
      if (mode == 2) begin
         flip = $urandom_range(0, NUM_DIGITS - 1);
         keys[flip] = (keys[flip] + $urandom_range(1, 15)) % 16;
      end else if (mode == 3) begin
         foreach (keys[i]) keys[i] = $urandom_range(0, 15);
      end
      foreach (keys[i]) tap_key(keys[i], hold);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.idx <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      csr_chan.valid <= 1'b0;
      if (idx == CSR_DEBOUNCE_TICKS) debounce_cfg = val;
      else if (idx == CSR_SCAN_PERIOD_TICKS) period_cfg = val;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (results_seen < ticks_queued);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] debounce, input logic [7:0] period,
                            input int groups, input int noise_ticks);
      int hold;
      write_reg(CSR_DEBOUNCE_TICKS, debounce);
      write_reg(CSR_SCAN_PERIOD_TICKS, period);
      gen_period = period;
      // long enough for the hold-off to expire and the column to come round
      hold = debounce + 4 * (period == 0 ? 1 : period) + 2;
      repeat (groups) enter_group(hold);
      repeat (noise_ticks) queue_tick(1'b1, 4'($urandom_range(0, 15)));
      wait_idle();
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.row_lines <= 4'hF;
         req_wait <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            lock_tick(req_chan.row_lines);
            ticks_taken++;
            if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_wait != 0) begin
               req_wait <= req_wait - 1;
               req_chan.valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               req_chan.valid <= 1'b1;
               req_chan.row_lines <= tick_q.pop_front();
               req_wait <= idle_draw(req_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      int              gap;
      lock_status_type want;
      lock_status_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         gap = (rsp_wait != 0) ? rsp_wait - 1 : 0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            got.column_drive = rsp_chan.column_drive;
            got.segments = rsp_chan.segments;
            got.digit_select = rsp_chan.digit_select;
            got.unlocked = rsp_chan.unlocked;
            got.key_accepted = rsp_chan.key_accepted;
            got.key_code = rsp_chan.key_code;
            if (status_q.size() == 0) begin
               if (errors < 10)
                  $display("response %0d with nothing expected: col %0d seg %02h",
                           results_seen, got.column_drive, got.segments);
               errors++;
            end else begin
               want = status_q.pop_front();
               if (got.column_drive !== want.column_drive || got.segments !== want.segments ||
                   got.digit_select !== want.digit_select ||
                   got.unlocked !== want.unlocked ||
                   got.key_accepted !== want.key_accepted ||
                   got.key_code !== want.key_code) begin
                  if (errors < 10) begin
                     $display("response %0d expected col %0d seg %02h sel %03b unl %0b acc %0b key %0d",
                              results_seen, want.column_drive, want.segments, want.digit_select,
                              want.unlocked, want.key_accepted, want.key_code);
                     $display("response %0d actual   col %0d seg %02h sel %03b unl %0b acc %0b key %0d",
                              results_seen, got.column_drive, got.segments, got.digit_select,
                              got.unlocked, got.key_accepted, got.key_code);
                  end
                  errors++;
               end
            end
            if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
            gap = idle_draw(rsp_calm);
         end
         rsp_wait <= gap;
         rsp_chan.ready <= (gap == 0) && !long_stall;
      end
   end

   // hold the response side off long enough for the intake to fill
   initial begin
      wait (ticks_taken >= 150);
      @(posedge clock);
      long_stall <= 1'b1;
      repeat (150) @(posedge clock);
      long_stall <= 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.row_lines = 4'hF;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.idx = '0;
      csr_chan.data = '0;

      debounce_cfg = DEBOUNCE_RESET;
      period_cfg = SCAN_PERIOD_RESET;
      scan_col = '0;
      col_timer = '0;
      change_timer = '0;
      foreach (last_key[i]) last_key[i] = NO_KEY;
      digit_count = 0;
      foreach (attempt[i]) attempt[i] = '0;
      foreach (secret[i]) secret[i] = '0;
      is_locked = 1'b0;
      code_ready = 1'b0;
      disp_seg = SEG_BLANK;
      disp_sel = '0;

      gen_col = 0;
      gen_timer = 0;
      gen_period = SCAN_PERIOD_RESET;
      foreach (pad[i]) pad[i] = 4'h0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // opening run, one column per tick: set the code, match it, then a wrong
      // group with star, hash and multi-row presses
      write_reg(CSR_DEBOUNCE_TICKS, 8'd0);
      write_reg(CSR_SCAN_PERIOD_TICKS, 8'd1);
      gen_period = 1;
      foreach (opening_rows[i]) queue_tick(1'b1, opening_rows[i]);
      wait_idle();

      run_phase(8'd1, 8'd1, 5, 0);
      run_phase(8'd4, 8'd2, 2, 0);
      run_phase(8'd0, 8'd0, 5, 60);
      // no change can ever pass the hold-off
      run_phase(8'd255, 8'd3, 0, 60);
      run_phase(8'd0, 8'd255, 0, 40);

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/kcl_pkg.sv
rtl/core/kcl_if.sv
rtl/core/kcl_front.sv
rtl/core/kcl_engine.sv
rtl/core/keypad_combination_lock.sv
tb/tb_top.sv
